// File: src/ltc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the LTC box stream compressor.
// No dependencies; the interfaces, the top level and the lanes import this package.
package ltc_pkg;

    localparam int AXES    = 3;
    localparam int VAL_W   = 32;
    localparam int TIME_W  = 32;
    localparam int EPS_W   = 31;
    localparam int KIND_W  = 2;
    localparam int WIDE_W  = 36;

    localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLUSHED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXTRAP  = 2'd2;

    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_BASE  = 2'd1;
    localparam logic [1:0] PHASE_BOX   = 2'd2;

    // Commands from the sequencer to every lane.
    typedef struct packed {
        logic load_base;
        logic open_box;
        logic div_start;
        logic narrow;
        logic mul_go;
        logic move_base;
        logic clear;
    } lane_ctrl_t;

    typedef logic signed [VAL_W-1:0] val_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic val_t sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(32'sh7FFF_FFFF);
        lo = -WIDE_W'(33'sh0_8000_0000);
        if (x > hi)
            return val_t'(32'sh7FFF_FFFF);
        else if (x < lo)
            return val_t'(32'sh8000_0000);
        else
            return x[VAL_W-1:0];
    endfunction

endpackage

// File: src/ltc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples and emitted points.
// Depends on ltc_pkg for the payload widths.
interface ltc_in_if;
    import ltc_pkg::*;
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   sample_time;
    logic signed [VAL_W-1:0] value_x;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_z;
    logic                end_of_stream;

    modport source (output valid, sample_time, value_x, value_y, value_z, end_of_stream,
                    input ready);
    modport sink   (input valid, sample_time, value_x, value_y, value_z, end_of_stream,
                    output ready);
endinterface

interface ltc_out_if;
    import ltc_pkg::*;
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   out_time;
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic [KIND_W-1:0]   point_kind;
    logic                last_of_run;

    modport source (output valid, out_time, out_x, out_y, out_z, point_kind, last_of_run,
                    input ready);
    modport sink   (input valid, out_time, out_x, out_y, out_z, point_kind, last_of_run,
                    output ready);
endinterface

// File: src/ltc_box_stream_compressor.sv
`timescale 1ns / 1ps
// Top level of the LTC box stream compressor: sequencer, lanes and output register.
// Depends on ltc_pkg, ltc_if, ltc_serial_div and ltc_lane.
//
//   Channel    Direction  Handshake        Carries
//   in_req     sink       valid/ready      sample_time, value_x/y/z, end_of_stream
//   out_req    source     valid/ready      out_time, out_x/y/z, point_kind, last_of_run
//   cfg        write only cfg_write_en     epsilon (31 bits), no read-back
//
// A request that keeps the box open goes from its acceptance through a dispatch state, the
// per-axis serial dividers (33 quotient bits, one a cycle, then a state that sees them
// finish) and a compare/narrow state before the next request is accepted.
// The first two requests of a stream and dropped requests skip the dividers.
// Each emitted point waits in its state while out_req stalls; the output
// register lets one point wait downstream while the sequencer works on.
// Reset is asynchronous, active low, and returns the compressor to "no base point yet".
module ltc_box_stream_compressor #(
    parameter int DIMENSIONS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [30:0]        cfg_write_data,
    ltc_in_if.sink             in_req,
    ltc_out_if.source          out_req
);
    import ltc_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DISPATCH  = 4'd1;
    localparam logic [3:0] ST_DIV       = 4'd2;
    localparam logic [3:0] ST_CHECK     = 4'd3;
    localparam logic [3:0] ST_EMIT_SENT = 4'd4;
    localparam logic [3:0] ST_MOVE      = 4'd5;
    localparam logic [3:0] ST_EMIT_BASE = 4'd6;
    localparam logic [3:0] ST_EMIT_EXT  = 4'd7;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [30:0]       eps_reg;
    logic [31:0]       base_time_reg, base_time_next;
    logic [31:0]       last_time_reg, last_time_next;
    logic [31:0]       t_reg;
    val_t              v_reg [AXES];
    logic              eos_reg;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_time_reg, out_time_next;
    val_t              out_val_reg [AXES];
    val_t              out_val_next [AXES];
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;

    lane_ctrl_t        ctrl;
    logic [31:0]       td, n_steps;
    logic [32:0]       eps_quo;
    logic              eps_busy;
    logic              div_start;
    logic [AXES-1:0]   lane_busy, lane_outside;
    val_t              base_val [AXES];
    val_t              moved_val [AXES];
    logic              slot_free, accept, any_outside;

    assign slot_free   = !out_valid_reg || out_req.ready;
    assign accept      = in_req.valid && in_req.ready;
    assign in_req.ready = (state_reg == ST_IDLE);
    assign td          = t_reg - base_time_reg;
    assign any_outside = |lane_outside;
    assign div_start   = ctrl.div_start;

    // The error bound is scaled by the gap alongside the per-axis projections.
    ltc_serial_div #(.NUM_W(33), .DEN_W(32)) u_eps_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({2'b00, eps_reg}),
        .den   (td),
        .busy  (eps_busy),
        .quo   (eps_quo)
    );

    genvar g;
    generate
        for (g = 0; g < AXES; g++)
        begin : g_axis
            if (g < DIMENSIONS)
            begin : g_lane
                ltc_lane u_lane (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .sample_val (v_reg[g]),
                    .td         (td),
                    .n_steps    (n_steps),
                    .epsilon    (eps_reg),
                    .eps_scaled (eps_quo[31:0]),
                    .div_busy   (lane_busy[g]),
                    .outside    (lane_outside[g]),
                    .base_val   (base_val[g]),
                    .moved_val  (moved_val[g])
                );
            end
            else
            begin : g_none
                assign lane_busy[g]    = 1'b0;
                assign lane_outside[g] = 1'b0;
                assign base_val[g]     = '0;
                assign moved_val[g]    = '0;
            end
        end
    endgenerate

    // Sequencer: walks one request through its decisions and emissions.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        base_time_next = base_time_reg;
        last_time_next = last_time_reg;
        out_valid_next = out_valid_reg && !out_req.ready;
        out_time_next  = out_time_reg;
        out_val_next   = out_val_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;
        n_steps        = last_time_reg - base_time_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (phase_reg == PHASE_EMPTY)
                begin
                    ctrl.load_base = 1'b1;
                    base_time_next = t_reg;
                    last_time_next = t_reg;
                    phase_next     = PHASE_BASE;
                    state_next     = eos_reg ? ST_EMIT_BASE : ST_IDLE;
                end
                else if (t_reg <= last_time_reg)
                begin
                    // A timestamp that does not move forward is dropped.
                    state_next = eos_reg ? ST_EMIT_BASE : ST_IDLE;
                end
                else if (phase_reg == PHASE_BASE)
                begin
                    ctrl.open_box  = 1'b1;
                    last_time_next = t_reg;
                    phase_next     = PHASE_BOX;
                    state_next     = eos_reg ? ST_EMIT_BASE : ST_IDLE;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!eps_busy && (lane_busy == '0))
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (any_outside)
                    state_next = ST_EMIT_SENT;
                else
                begin
                    ctrl.narrow    = 1'b1;
                    last_time_next = t_reg;
                    state_next     = eos_reg ? ST_EMIT_BASE : ST_IDLE;
                end
            end
            ST_EMIT_SENT:
            begin
                // Transmit the base, and start the midline step to one unit before now.
                n_steps = t_reg - 32'd1 - base_time_reg;
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = base_time_reg;
                    out_val_next   = base_val;
                    out_kind_next  = KIND_SENT;
                    out_last_next  = !eos_reg;
                    ctrl.mul_go    = 1'b1;
                    state_next     = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                // With a gap of one the narrowed box equals the freshly opened one.
                ctrl.move_base = 1'b1;
                ctrl.open_box  = 1'b1;
                base_time_next = t_reg - 32'd1;
                last_time_next = t_reg;
                state_next     = eos_reg ? ST_EMIT_BASE : ST_IDLE;
            end
            ST_EMIT_BASE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = base_time_reg;
                    out_val_next   = base_val;
                    out_kind_next  = KIND_FLUSHED;
                    out_last_next  = (phase_reg != PHASE_BOX);
                    if (phase_reg == PHASE_BOX)
                    begin
                        ctrl.mul_go = 1'b1;
                        state_next  = ST_EMIT_EXT;
                    end
                    else
                    begin
                        ctrl.clear     = 1'b1;
                        phase_next     = PHASE_EMPTY;
                        base_time_next = '0;
                        last_time_next = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_EMIT_EXT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_time_next  = last_time_reg;
                    out_val_next   = moved_val;
                    out_kind_next  = KIND_EXTRAP;
                    out_last_next  = 1'b1;
                    ctrl.clear     = 1'b1;
                    phase_next     = PHASE_EMPTY;
                    base_time_next = '0;
                    last_time_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PHASE_EMPTY;
            eps_reg       <= 31'd6553600;
            base_time_reg <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            base_time_reg <= base_time_next;
            last_time_reg <= last_time_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                eps_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg    <= in_req.sample_time;
            v_reg[0] <= in_req.value_x;
            v_reg[1] <= in_req.value_y;
            v_reg[2] <= in_req.value_z;
            eos_reg  <= in_req.end_of_stream;
        end
        out_time_reg <= out_time_next;
        out_val_reg  <= out_val_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign out_req.valid       = out_valid_reg;
    assign out_req.out_time    = out_time_reg;
    assign out_req.out_x       = out_val_reg[0];
    assign out_req.out_y       = out_val_reg[1];
    assign out_req.out_z       = out_val_reg[2];
    assign out_req.point_kind  = out_kind_reg;
    assign out_req.last_of_run = out_last_reg;

    // The phase never takes its unused code.
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("phase register holds an unused code");

    // An extrapolated point always closes its run.
    a_extrap_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_req.valid && out_req.point_kind == KIND_EXTRAP) |-> out_req.last_of_run)
        else $error("extrapolated point without last_of_run");

    // A new request is taken only when no division is in flight.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!eps_busy && lane_busy == '0))
        else $error("request accepted while dividers busy");

    // Dividers are started only from the dispatch state with a box open.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == ST_DISPATCH && phase_reg == PHASE_BOX))
        else $error("divider started outside dispatch");
endmodule

// File: src/ltc_serial_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the lanes and by the error-bound scaling.
module ltc_serial_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(shifted - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
endmodule

// File: src/ltc_lane.sv
`timescale 1ns / 1ps
// One axis of the compressor: base point, slope box, projection divider and midline step.
// Depends on ltc_pkg and ltc_serial_div.
module ltc_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ltc_pkg::lane_ctrl_t        ctrl,
    input  logic signed [31:0]         sample_val,
    input  logic [31:0]                td,
    input  logic [31:0]                n_steps,
    input  logic [30:0]                epsilon,
    input  logic [31:0]                eps_scaled,
    output logic                       div_busy,
    output logic                       outside,
    output logic signed [31:0]         base_val,
    output logic signed [31:0]         moved_val
);
    import ltc_pkg::*;

    val_t base_reg, upper_reg, lower_reg;
    logic signed [32:0] diff_v;
    logic [32:0]        diff_mag;
    logic               qneg_reg;
    logic [32:0]        quo;
    logic signed [WIDE_W-1:0] q_s, proj, mid, half, dev, dev_abs, e_w, hi_w, lo_w;
    val_t               hi, lo;
    logic signed [WIDE_W-1:0] mdiff;
    logic [33:0]        mmag;
    logic [65:0]        prod_reg;
    logic               pneg_reg;
    logic [33:0]        clamped;
    logic signed [WIDE_W-1:0] step_s;
    val_t               moved;

    assign diff_v   = 33'(sample_val) - 33'(base_reg);
    assign diff_mag = diff_v[32] ? 33'(-diff_v) : 33'(diff_v);

    ltc_serial_div #(.NUM_W(33), .DEN_W(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (diff_mag),
        .den   (td),
        .busy  (div_busy),
        .quo   (quo)
    );

    always_comb
    begin
        q_s     = qneg_reg ? -WIDE_W'($signed({1'b0, quo})) : WIDE_W'($signed({1'b0, quo}));
        proj    = WIDE_W'(base_reg) + q_s;
        mid     = (WIDE_W'(upper_reg) + WIDE_W'(lower_reg)) >>> 1;
        half    = (WIDE_W'(upper_reg) - WIDE_W'(lower_reg)) >>> 1;
        e_w     = WIDE_W'($signed({1'b0, eps_scaled}));
        dev     = proj - mid;
        dev_abs = dev[WIDE_W-1] ? -dev : dev;
        hi_w    = proj + e_w;
        lo_w    = proj - e_w;
        hi      = sat32(hi_w);
        lo      = sat32(lo_w);
        mdiff   = mid - WIDE_W'(base_reg);
        mmag    = mdiff[WIDE_W-1] ? 34'(-mdiff) : 34'(mdiff);
        // The midline step is clamped to 2^33 in magnitude before it is added.
        clamped = (prod_reg > 66'(34'h2_0000_0000)) ? 34'h2_0000_0000 : prod_reg[33:0];
        step_s  = pneg_reg ? -WIDE_W'({2'b00, clamped}) : WIDE_W'({2'b00, clamped});
        moved   = sat32(WIDE_W'(base_reg) + step_s);
    end

    assign outside = dev_abs > (half + e_w);

    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
            qneg_reg <= diff_v[32];
        if (ctrl.mul_go)
        begin
            prod_reg <= mmag * n_steps;
            pneg_reg <= mdiff[WIDE_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            upper_reg <= '0;
            lower_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            base_reg  <= '0;
            upper_reg <= '0;
            lower_reg <= '0;
        end
        else
        begin
            if (ctrl.load_base)
                base_reg <= sample_val;
            else if (ctrl.move_base)
                base_reg <= moved;
            if (ctrl.open_box)
            begin
                upper_reg <= sat32(WIDE_W'(sample_val) + WIDE_W'({1'b0, epsilon}));
                lower_reg <= sat32(WIDE_W'(sample_val) - WIDE_W'({1'b0, epsilon}));
            end
            else if (ctrl.narrow)
            begin
                if (hi < upper_reg)
                    upper_reg <= hi;
                if (lo > lower_reg)
                    lower_reg <= lo;
            end
        end
    end

    assign base_val  = base_reg;
    assign moved_val = moved;
endmodule
